// ===== src/prq_pkg.sv =====
// Shared constants, codes and types of the priority ready-queue scheduler.
`default_nettype none

package prq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_BITS_DEF   = 8;
    localparam int PRIO_BITS_DEF   = 8;

    localparam int ARRIVAL_BITS = 32;
    localparam int CFG_BITS     = 5;
    localparam int COUNT_BITS   = 5;
    localparam int FUNC_BITS    = 2;
    localparam int ACTION_BITS  = 3;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_YIELD  = 2'd1,
        FUNC_EXIT   = 2'd2
    } t_func;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_START     = 3'd0,
        ACT_QUEUED    = 3'd1,
        ACT_SWITCH    = 3'd2,
        ACT_NONE_LEFT = 3'd3,
        ACT_FULL      = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== src/prq_in_if.sv =====
// Event channel into the scheduler: valid/ready plus the event fields.
`default_nettype none

interface prq_in_if import prq_pkg::*; #(
    parameter int TASK_BITS = TASK_BITS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_BITS-1:0] func;
    logic [TASK_BITS-1:0] task_id;
    logic [PRIO_BITS-1:0] priority_req;

    modport source (output valid, output func, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input func, input task_id, input priority_req,
                    output ready);
endinterface

`default_nettype wire

// ===== src/prq_out_if.sv =====
// Result channel out of the scheduler: valid/ready plus the result fields.
`default_nettype none

interface prq_out_if import prq_pkg::*; #(
    parameter int TASK_BITS = TASK_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic [TASK_BITS-1:0]   run_task;
    logic [COUNT_BITS-1:0]  waiting;
    logic [COUNT_BITS-1:0]  running;

    modport source (output valid, output action, output run_task, output waiting,
                    output running, input ready);
    modport sink   (input valid, input action, input run_task, input waiting,
                    input running, output ready);
endinterface

`default_nettype wire

// ===== src/prq_slot_mem.sv =====
// Queue slot storage: one write port, one read port with registered read data.
`default_nettype none

module prq_slot_mem import prq_pkg::*; #(
    parameter int DEPTH     = QUEUE_DEPTH_DEF,
    parameter int DATA_BITS = PRIO_BITS_DEF + TASK_BITS_DEF + ARRIVAL_BITS,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/priority_ready_queue_scheduler.sv =====
// Top level of the priority ready-queue scheduler.
`default_nettype none

// Ready-queue scheduler: create, yield and exit events come in one item at a time and each
// gives exactly one result item. A create that finds a free worker (fewer busy workers than
// the worker limit) skips the scan: it goes from acceptance straight to the finish state,
// which loads the registered result. Every other event scans all QUEUE_DEPTH slots through
// the single read port of the slot memory, one slot per cycle into one shared comparator of
// priority and arrival, then passes the last and finish states before its result is loaded.
// A result not yet taken holds the next back in finish; the event channel is ready only in
// idle, so no new item is taken before the last one is finished. The best slot has the
// lowest priority number, then the oldest arrival, then the lowest index. The worker limit
// resets to 1; the user must write it only while the block is idle; the block does not check.
module priority_ready_queue_scheduler import prq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TASK_BITS   = TASK_BITS_DEF,
    parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    prq_in_if.sink              i_evt,
    prq_out_if.source           o_res,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata
);

    localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_BITS = PRIO_BITS + TASK_BITS + ARRIVAL_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(QUEUE_DEPTH - 1);

    // control state
    t_state                  r_state, n_state;
    logic [CFG_BITS-1:0]     r_worker_limit;
    logic [COUNT_BITS-1:0]   r_busy, n_busy;
    logic [CNT_BITS-1:0]     r_count, n_count;
    logic [ARRIVAL_BITS-1:0] r_arrival, n_arrival;
    logic [QUEUE_DEPTH-1:0]  r_valid;
    logic                    r_out_valid;
    logic                    r_cmp_vld;

    // current event and scan results
    t_func                   r_func, n_func;
    logic [TASK_BITS-1:0]    r_task;
    logic [PRIO_BITS-1:0]    r_prio;
    logic [IDX_BITS-1:0]     r_issue;
    logic [IDX_BITS-1:0]     r_cmp_idx;
    logic                    r_cmp_sv;
    logic                    r_best_found;
    logic [PRIO_BITS-1:0]    r_best_prio;
    logic [ARRIVAL_BITS-1:0] r_best_arr;
    logic [TASK_BITS-1:0]    r_best_task;
    logic [IDX_BITS-1:0]     r_best_idx;
    logic                    r_free_found;
    logic [IDX_BITS-1:0]     r_free_idx;

    // result register
    t_action                 r_out_action, n_action;
    logic [TASK_BITS-1:0]    r_out_run, n_run;
    logic [COUNT_BITS-1:0]   r_out_waiting;
    logic [COUNT_BITS-1:0]   r_out_running;

    logic                    evt_accept;
    logic                    fin_go;
    logic                    can_start;
    logic                    valid_set;
    logic                    valid_clr;
    logic                    mem_we;
    logic [IDX_BITS-1:0]     mem_waddr;
    logic [DATA_BITS-1:0]    mem_wdata;
    logic [DATA_BITS-1:0]    mem_rdata;
    logic [PRIO_BITS-1:0]    rd_prio;
    logic [TASK_BITS-1:0]    rd_task;
    logic [ARRIVAL_BITS-1:0] rd_arr;
    logic [PRIO_BITS-1:0]    cand_prio;
    logic [ARRIVAL_BITS-1:0] cand_arr;
    logic                    cand_better;

    prq_slot_mem #(
        .DEPTH     (QUEUE_DEPTH),
        .DATA_BITS (DATA_BITS),
        .ADDR_BITS (IDX_BITS)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_issue),
        .o_rdata (mem_rdata)
    );

    assign rd_prio = mem_rdata[DATA_BITS-1 -: PRIO_BITS];
    assign rd_task = mem_rdata[ARRIVAL_BITS +: TASK_BITS];
    assign rd_arr  = mem_rdata[ARRIVAL_BITS-1:0];

    assign i_evt.ready = (r_state == ST_IDLE);
    assign evt_accept  = i_evt.valid && (r_state == ST_IDLE);
    assign fin_go      = (r_state == ST_FINISH) && (!r_out_valid || o_res.ready);
    assign can_start   = (r_busy < r_worker_limit);
    assign mem_wdata   = {r_prio, r_task, r_arrival};

    // fold the unused code into exit
    always_comb begin
        case (i_evt.func)
            FUNC_CREATE: n_func = FUNC_CREATE;
            FUNC_YIELD:  n_func = FUNC_YIELD;
            default:     n_func = FUNC_EXIT;
        endcase
    end

    // shared comparator: slot read data during the scan, the yielding caller at finish
    always_comb begin
        if (r_state == ST_FINISH) begin
            cand_prio = r_prio;
            cand_arr  = r_arrival;
        end else begin
            cand_prio = rd_prio;
            cand_arr  = rd_arr;
        end
        cand_better = !r_best_found || (cand_prio < r_best_prio) ||
                      ((cand_prio == r_best_prio) && (cand_arr < r_best_arr));
    end

    always_comb begin
        n_state   = r_state;
        n_busy    = r_busy;
        n_count   = r_count;
        n_arrival = r_arrival;
        n_action  = ACT_SWITCH;
        n_run     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_best_idx;
        valid_set = 1'b0;
        valid_clr = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (evt_accept) begin
                    n_state = ((n_func == FUNC_CREATE) && can_start) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_issue == LAST_IDX) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                    case (r_func)
                        FUNC_CREATE: begin
                            if (can_start) begin
                                n_busy   = r_busy + 1'b1;
                                n_action = ACT_START;
                                n_run    = r_task;
                            end else if (!r_free_found) begin
                                n_action = ACT_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_free_idx;
                                valid_set = 1'b1;
                                n_count   = r_count + 1'b1;
                                n_arrival = r_arrival + 1'b1;
                                n_action  = ACT_QUEUED;
                            end
                        end
                        FUNC_YIELD: begin
                            n_arrival = r_arrival + 1'b1;
                            if (cand_better) begin
                                n_run = r_task;
                            end else begin
                                // caller takes over the winner's slot
                                n_run  = r_best_task;
                                mem_we = 1'b1;
                            end
                        end
                        default: begin
                            if (!r_best_found) begin
                                n_action = ACT_NONE_LEFT;
                                if (r_busy != '0) begin
                                    n_busy = r_busy - 1'b1;
                                end
                            end else begin
                                n_run     = r_best_task;
                                valid_clr = 1'b1;
                                n_count   = r_count - 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_worker_limit <= CFG_BITS'(1);
            r_busy         <= '0;
            r_count        <= '0;
            r_arrival      <= '0;
            r_valid        <= '0;
            r_out_valid    <= 1'b0;
            r_cmp_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_worker_limit <= i_cfg_wdata;
            end
            r_state   <= n_state;
            r_busy    <= n_busy;
            r_count   <= n_count;
            r_arrival <= n_arrival;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (valid_set) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (valid_clr) begin
                r_valid[r_best_idx] <= 1'b0;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_issue;
        r_cmp_sv  <= r_valid[r_issue];
        if (evt_accept) begin
            r_func       <= n_func;
            r_task       <= i_evt.task_id;
            r_prio       <= i_evt.priority_req;
            r_issue      <= '0;
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (r_state == ST_SCAN) begin
                r_issue <= r_issue + 1'b1;
            end
            if (r_cmp_vld && r_cmp_sv && cand_better) begin
                r_best_found <= 1'b1;
                r_best_prio  <= rd_prio;
                r_best_arr   <= rd_arr;
                r_best_task  <= rd_task;
                r_best_idx   <= r_cmp_idx;
            end
            // first empty slot wins
            if (r_cmp_vld && !r_cmp_sv && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
        end
        if (fin_go) begin
            r_out_action  <= n_action;
            r_out_run     <= n_run;
            r_out_waiting <= COUNT_BITS'(n_count);
            r_out_running <= n_busy;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.action   = r_out_action;
    assign o_res.run_task = r_out_run;
    assign o_res.waiting  = r_out_waiting;
    assign o_res.running  = r_out_running;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == r_count)
        else $error("queue fill count differs from the number of valid slots");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> !i_evt.ready)
        else $error("event channel still ready after an item was taken");

    a_finish_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("finished event did not present a result");
`endif

endmodule

`default_nettype wire
